FILE: sv/ils_pkg.sv
// Shared types, codes and a helper function of the integer literal scanner.
package ils_pkg;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NODIGITS = 2'd3;

    localparam logic [1:0] OP_DIGIT   = 2'd0;
    localparam logic [1:0] OP_SKIP    = 2'd1;
    localparam logic [1:0] OP_INVALID = 2'd2;
    localparam logic [1:0] OP_PREFIX  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;

    localparam logic [63:0] LIMIT_DEC = 64'h1999_9999_9999_9999;
    localparam logic [63:0] LIMIT_HEX = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_BIN = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [3:0]  SPARE_DEC = 4'd5;
    localparam logic [3:0]  SPARE_HEX = 4'd15;
    localparam logic [3:0]  SPARE_BIN = 4'd1;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_REST   = 2'd2;

    typedef logic [1:0] t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic [1:0] radix;
        logic       is_last;
    } t_beat;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_result;

    // bit 4 set when the character is a hex digit, low bits give its value
    function automatic logic [4:0] f_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

endpackage

FILE: sv/ils_fifo.sv
// Small first-in first-out queue used between the scanner stages and for the results.
module ils_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/ils_front.sv
// Front stage: tracks literal position and radix and classifies each character.
module ils_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_ch,
    input  logic          i_is_last,
    output ils_pkg::t_beat o_beat
);
    import ils_pkg::*;

    logic [1:0] r_pos, n_pos;
    logic       r_first_zero, n_first_zero;
    logic [1:0] r_radix, n_radix;
    logic [4:0] w_dig;
    logic       w_fz;
    logic       w_is_x, w_is_b;
    logic       w_fits;

    assign w_dig  = f_digit(i_ch);
    assign w_fz   = r_first_zero || (r_pos == POS_FIRST && i_ch == CH_ZERO && !i_is_last);
    assign w_is_x = (i_ch == CH_LX) || (i_ch == CH_UX);
    assign w_is_b = (i_ch == CH_LB) || (i_ch == CH_UB);

    always_comb begin
        case (r_radix)
            RADIX_HEX: w_fits = 1'b1;
            RADIX_BIN: w_fits = (w_dig[3:0] <= 4'd1);
            default:   w_fits = (w_dig[3:0] <= 4'd9);
        endcase
    end

    always_comb begin
        o_beat.digit   = w_dig[3:0];
        o_beat.is_last = i_is_last;
        o_beat.radix   = r_radix;
        n_radix        = r_radix;
        if (r_pos == POS_SECOND && w_fz && !i_is_last && (w_is_x || w_is_b)) begin
            o_beat.op = OP_PREFIX;
            n_radix   = w_is_x ? RADIX_HEX : RADIX_BIN;
        end else if (i_ch == CH_UNDER) begin
            o_beat.op = OP_SKIP;
        end else if (w_dig[4] && w_fits) begin
            o_beat.op = OP_DIGIT;
        end else begin
            o_beat.op = OP_INVALID;
        end
        n_first_zero = w_fz;
        n_pos        = (r_pos == POS_REST) ? POS_REST : r_pos + 1'b1;
        if (i_is_last) begin
            n_radix      = RADIX_DEC;
            n_first_zero = 1'b0;
            n_pos        = POS_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_FIRST;
            r_first_zero <= 1'b0;
            r_radix      <= RADIX_DEC;
        end else if (i_take) begin
            r_pos        <= n_pos;
            r_first_zero <= n_first_zero;
            r_radix      <= n_radix;
        end
    end

endmodule

FILE: sv/ils_back.sv
// Back stage: accumulates digit beats with overflow check and forms results.
module ils_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ils_pkg::t_beat   i_beat,
    output logic             o_take,
    input  logic             i_out_full,
    output logic             o_res_push,
    output ils_pkg::t_result o_res
);
    import ils_pkg::*;

    logic [63:0] r_acc, n_acc;
    logic        r_saw, n_saw;
    logic [1:0]  r_err, n_err;
    logic [63:0] w_limit;
    logic [3:0]  w_spare;
    logic [63:0] w_next;
    logic        w_ovf;

    assign o_take = i_valid && !i_out_full;

    always_comb begin
        case (i_beat.radix)
            RADIX_HEX: begin
                w_limit = LIMIT_HEX;
                w_spare = SPARE_HEX;
                w_next  = {r_acc[59:0], i_beat.digit};
            end
            RADIX_BIN: begin
                w_limit = LIMIT_BIN;
                w_spare = SPARE_BIN;
                w_next  = {r_acc[62:0], 1'b0} + 64'(i_beat.digit);
            end
            default: begin
                w_limit = LIMIT_DEC;
                w_spare = SPARE_DEC;
                w_next  = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0}
                        + 64'(i_beat.digit);
            end
        endcase
        w_ovf = (r_acc > w_limit) || (r_acc == w_limit && i_beat.digit > w_spare);
    end

    always_comb begin
        n_acc = r_acc;
        n_saw = r_saw;
        n_err = r_err;
        case (i_beat.op)
            OP_PREFIX: begin
                n_acc = '0;
                n_saw = 1'b0;
            end
            OP_INVALID: begin
                if (r_err == ST_OK) begin
                    n_err = ST_INVALID;
                end
            end
            OP_DIGIT: begin
                if (r_err == ST_OK) begin
                    if (w_ovf) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        n_acc = w_next;
                        n_saw = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (n_err != ST_OK) begin
            o_res.status = n_err;
        end else if (!n_saw) begin
            o_res.status = ST_NODIGITS;
        end else begin
            o_res.status = ST_OK;
        end
        o_res.value = (o_res.status == ST_OK) ? n_acc : '0;
        o_res_push  = o_take && i_beat.is_last;

        if (i_beat.is_last) begin
            n_acc = '0;
            n_saw = 1'b0;
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_saw <= 1'b0;
            r_err <= ST_OK;
        end else if (o_take) begin
            r_acc <= n_acc;
            r_saw <= n_saw;
            r_err <= n_err;
        end
    end

endmodule

FILE: sv/integer_literal_scanner_unit.sv
// Top level of the integer literal scanner: front stage, beat queue, back stage, result queue.
// A character accepted into the beat queue is applied by the back stage from the queue head
//   while the result queue has room; a result is queued when its last character is taken.
// Throughput: one character per cycle while neither queue is full.
// Reset: synchronous active-low i_rst_n empties both queues and clears all scan state.
// MID_DEPTH and OUT_DEPTH must be powers of two, at least two.
module integer_literal_scanner_unit #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_value,
    output logic [1:0]  o_status
);
    import ils_pkg::*;

    t_beat   w_front_beat;
    t_beat   w_back_beat;
    t_result w_res;
    t_result w_out;
    logic    w_take_in;
    logic    w_mid_empty;
    logic    w_back_take;
    logic    w_out_full;
    logic    w_res_push;

    assign w_take_in = push && !full;

    ils_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take_in),
        .i_ch      (i_ch),
        .i_is_last (i_is_last),
        .o_beat    (w_front_beat)
    );

    ils_fifo #(
        .WIDTH ($bits(t_beat)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_beat),
        .o_full  (full),
        .i_pop   (w_back_take),
        .o_data  (w_back_beat),
        .o_empty (w_mid_empty)
    );

    ils_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_mid_empty),
        .i_beat     (w_back_beat),
        .o_take     (w_back_take),
        .i_out_full (w_out_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    ils_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_value  = w_out.value;
    assign o_status = w_out.status;

endmodule

FILE: sv/ils_checker.sv
// Port-level checks for the integer literal scanner, bound to the top level.
module ils_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_value,
    input logic [1:0]  o_status
);
    import ils_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_value == '0))
        else $error("nonzero value on failing status");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_status)))
        else $error("waiting result changed");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_value, o_status}))
        else $error("unknown bits on a waiting result");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(full)) |-> $past(push))
        else $error("input queue filled without a push");

endmodule

bind integer_literal_scanner_unit ils_checker u_ils_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_value  (o_value),
    .o_status (o_status)
);
